@@ rtl/lrs_pkg.sv @@
`default_nettype none
package lrs_pkg;

    // phase codes
    localparam logic [2:0] PH_UNINIT     = 3'd0;
    localparam logic [2:0] PH_NOCREDS    = 3'd1;
    localparam logic [2:0] PH_CONNECTING = 3'd2;
    localparam logic [2:0] PH_RETRYWAIT  = 3'd3;
    localparam logic [2:0] PH_ONLINE     = 3'd4;
    localparam logic [2:0] PH_PROVISION  = 3'd5;
    localparam logic [2:0] PH_FAILED     = 3'd6;

    // event codes
    localparam logic [2:0] CMD_BEGIN      = 3'd0;
    localparam logic [2:0] CMD_CONN_START = 3'd1;
    localparam logic [2:0] CMD_CONNECTED  = 3'd2;
    localparam logic [2:0] CMD_DISCONN    = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;
    localparam logic [2:0] CMD_FAIL       = 3'd5;

    // action codes
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_CONNECT   = 2'd1;
    localparam logic [1:0] ACT_PROVISION = 2'd2;

    // register indexes
    localparam logic [1:0] REG_RETRY_BASE = 2'd0;
    localparam logic [1:0] REG_RETRY_MAX  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_FAIL_LIMIT = 2'd3;

    localparam logic [31:0] RETRY_BASE_RST = 32'd1000;
    localparam logic [31:0] RETRY_MAX_RST  = 32'd8000;
    localparam logic [31:0] TIMEOUT_RST    = 32'd30000;
    localparam logic [7:0]  FAIL_LIMIT_RST = 8'd3;

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [1:0] SHIFT_CAP = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_ms;
        logic        has_creds;
        logic        accepted;
        logic [15:0] drop_reason;
        logic        cred_failure;
    } lrs_event_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        creds_known;
        logic [7:0]  retry_count;
        logic [7:0]  cred_fail_count;
        logic [31:0] overall_deadline;
        logic [31:0] retry_time;
        logic [15:0] reason;
    } lrs_state_t;

    typedef struct packed {
        logic [31:0] backoff_base;
        logic [31:0] backoff_cap;
        logic [31:0] connect_timeout_ms;
        logic [7:0]  cred_fail_limit;
    } lrs_cfg_t;

    // due when the wrapped difference is non-negative
    function automatic logic is_due(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

endpackage
`default_nettype wire

@@ rtl/lrs_backoff.sv @@
`default_nettype none
module lrs_backoff (
    input  wire logic [31:0] base_ms,
    input  wire logic [31:0] cap_ms,
    input  wire logic [7:0]  retry_count,
    output logic [31:0]      delay_ms
);
    import lrs_pkg::*;

    logic [1:0]  shift;
    logic [34:0] wide;

    // cap the exponent, shift without loss, then clamp
    always_comb
    begin
        shift    = (retry_count >= {6'd0, SHIFT_CAP}) ? SHIFT_CAP : retry_count[1:0];
        wide     = {3'd0, base_ms} << shift;
        delay_ms = (wide > {3'd0, cap_ms}) ? cap_ms : wide[31:0];
    end

endmodule
`default_nettype wire

@@ rtl/lrs_core.sv @@
`default_nettype none
module lrs_core (
    input  wire lrs_pkg::lrs_event_t ev,
    input  wire lrs_pkg::lrs_state_t cur,
    input  wire lrs_pkg::lrs_cfg_t   cfg,
    output lrs_pkg::lrs_state_t      nxt,
    output logic [1:0]               action
);
    import lrs_pkg::*;

    logic        online;
    logic [7:0]  rc_base;
    logic [7:0]  cf_base;
    logic [7:0]  cf_inc;
    logic [7:0]  rc_inc;
    logic [31:0] delay_ms;
    logic        disc_ok;

    // counters as seen by a disconnect: cleared first when dropping from online
    assign online  = (cur.phase == PH_ONLINE);
    assign rc_base = online ? 8'd0 : cur.retry_count;
    assign cf_base = online ? 8'd0 : cur.cred_fail_count;
    assign cf_inc  = (ev.cred_failure && cf_base < COUNT_MAX) ? cf_base + 8'd1 : cf_base;
    assign rc_inc  = (rc_base < COUNT_MAX) ? rc_base + 8'd1 : rc_base;
    assign disc_ok = cur.creds_known && cur.phase != PH_FAILED && cur.phase != PH_PROVISION;

    lrs_backoff u_backoff (
        .base_ms     (cfg.backoff_base),
        .cap_ms      (cfg.backoff_cap),
        .retry_count (rc_inc),
        .delay_ms    (delay_ms)
    );

    always_comb
    begin
        nxt    = cur;
        action = ACT_NONE;
        unique case (ev.cmd)
            CMD_BEGIN:
            begin
                if (cur.phase == PH_UNINIT)
                begin
                    nxt.creds_known = ev.has_creds;
                    if (!ev.has_creds)
                    begin
                        nxt.phase = PH_NOCREDS;
                        action    = ACT_PROVISION;
                    end
                    else
                    begin
                        nxt.overall_deadline = ev.now_ms + cfg.connect_timeout_ms;
                        nxt.phase            = PH_CONNECTING;
                        action               = ACT_CONNECT;
                    end
                end
            end
            CMD_CONN_START:
            begin
                if (cur.phase == PH_CONNECTING || cur.phase == PH_RETRYWAIT)
                begin
                    nxt.phase = ev.accepted ? PH_CONNECTING : PH_FAILED;
                end
            end
            CMD_CONNECTED:
            begin
                if (cur.creds_known && cur.phase != PH_FAILED)
                begin
                    nxt.phase           = PH_ONLINE;
                    nxt.retry_count     = 8'd0;
                    nxt.cred_fail_count = 8'd0;
                    nxt.reason          = 16'd0;
                end
            end
            CMD_DISCONN:
            begin
                if (disc_ok)
                begin
                    nxt.reason          = ev.drop_reason;
                    nxt.cred_fail_count = cf_inc;
                    if (online)
                    begin
                        nxt.overall_deadline = ev.now_ms + cfg.connect_timeout_ms;
                    end
                    if (cf_inc >= cfg.cred_fail_limit)
                    begin
                        nxt.retry_count = rc_base;
                        nxt.phase       = PH_PROVISION;
                    end
                    else
                    begin
                        nxt.retry_count = rc_inc;
                        nxt.retry_time  = ev.now_ms + delay_ms;
                        nxt.phase       = PH_RETRYWAIT;
                    end
                end
            end
            CMD_TICK:
            begin
                priority if (cur.phase == PH_NOCREDS)
                begin
                    nxt.phase = PH_PROVISION;
                    action    = ACT_PROVISION;
                end
                else if ((cur.phase == PH_CONNECTING || cur.phase == PH_RETRYWAIT) &&
                         is_due(ev.now_ms, cur.overall_deadline))
                begin
                    nxt.phase = PH_PROVISION;
                    action    = ACT_PROVISION;
                end
                else if (cur.phase == PH_RETRYWAIT && is_due(ev.now_ms, cur.retry_time))
                begin
                    nxt.phase = PH_CONNECTING;
                    action    = ACT_CONNECT;
                end
                else
                begin
                    action = ACT_NONE;
                end
            end
            CMD_FAIL:
            begin
                nxt.phase = PH_FAILED;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/link_reconnect_supervisor_unit.sv @@
// Link reconnect supervisor.
// Input channel: one event beat per handshake (in_valid high, in_stall low),
// carrying cmd, now_ms and the per-event qualifiers. Output channel: one
// result beat per event (action, phase_now, last_reason), taken when
// out_valid is high and out_stall is low.
// Path: an event is held in the input register, evaluated against the
// supervisor state and written to the result register once that register is
// free or draining.
// Throughput: one event per cycle when not stalled; the state update and the
// result register load share one edge, so each event sees the state left by
// its predecessor; the single evaluation stage between the registers sets it.
// Stall: while the result register holds an untaken beat and the receiver
// stalls, the pending event stays in the input register and in_stall rises;
// the input register still takes a beat whenever it is empty or drains.
// Configuration: cfg_we writes register cfg_index (0 retry base, 1 retry
// max, 2 connect timeout, 3 credential-failure limit) at once; write only
// while no event is in flight.
// Reset: configuration registers return to their defaults, the phase to
// uninitialised and both channels empty; payload registers are not reset.
`default_nettype none
module link_reconnect_supervisor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] now_ms,
    input  wire logic        has_creds,
    input  wire logic        accepted,
    input  wire logic [15:0] drop_reason,
    input  wire logic        cred_failure,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       action,
    output logic [2:0]       phase_now,
    output logic [15:0]      last_reason
);
    import lrs_pkg::*;

    lrs_cfg_t   cfg_reg;
    lrs_state_t state_reg;
    lrs_state_t state_next;
    lrs_event_t ev_reg;
    logic       ev_vld_reg;
    logic       out_vld_reg;
    logic [1:0] act_next;
    logic [1:0] act_reg;
    logic [2:0] phase_reg;
    logic [15:0] reason_reg;
    logic       advance;
    logic       in_take;

    // evaluate the held event when the result register is free or draining
    assign advance  = ev_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = ev_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lrs_core u_core (
        .ev     (ev_reg),
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .nxt    (state_next),
        .action (act_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backoff_base       <= RETRY_BASE_RST;
            cfg_reg.backoff_cap        <= RETRY_MAX_RST;
            cfg_reg.connect_timeout_ms <= TIMEOUT_RST;
            cfg_reg.cred_fail_limit    <= FAIL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RETRY_BASE: cfg_reg.backoff_base       <= cfg_data;
                REG_RETRY_MAX:  cfg_reg.backoff_cap        <= cfg_data;
                REG_TIMEOUT:    cfg_reg.connect_timeout_ms <= cfg_data;
                REG_FAIL_LIMIT: cfg_reg.cred_fail_limit    <= cfg_data[7:0];
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // supervisor state: advance once per evaluated event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // input register and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                ev_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                ev_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload: hold the event beat, load the result beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg.cmd          <= cmd;
            ev_reg.now_ms       <= now_ms;
            ev_reg.has_creds    <= has_creds;
            ev_reg.accepted     <= accepted;
            ev_reg.drop_reason  <= drop_reason;
            ev_reg.cred_failure <= cred_failure;
        end
        if (advance)
        begin
            act_reg    <= act_next;
            phase_reg  <= state_next.phase;
            reason_reg <= state_next.reason;
        end
    end

    assign out_valid   = out_vld_reg;
    assign action      = act_reg;
    assign phase_now   = phase_reg;
    assign last_reason = reason_reg;

endmodule
`default_nettype wire

@@ bench/lrs_result_checker.sv @@
`timescale 1ns / 100ps

module lrs_result_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] now_ms,
    input  wire logic        has_creds,
    input  wire logic        accepted,
    input  wire logic [15:0] drop_reason,
    input  wire logic        cred_failure,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  phase_now,
    input  wire logic [15:0] last_reason,
    output int unsigned      mismatches,
    output int unsigned      pending
);
    import lrs_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  phase;
        logic [15:0] reason;
    } report_t;

    lrs_cfg_t    regs;
    lrs_state_t  link_state;
    report_t     owed_reports[$];
    int unsigned miss_tally;
    int unsigned beats_seen;

    // wrapped difference taken as a signed 32-bit number
    function automatic logic reached(input logic [31:0] stamp, input logic [31:0] mark);
        logic [31:0] gap;
        gap = stamp - mark;
        return $signed(gap) >= 0;
    endfunction

    function automatic logic [31:0] backoff_ms(input logic [7:0] tries,
                                               input logic [31:0] base,
                                               input logic [31:0] ceiling);
        logic [34:0] stretched;
        logic [1:0]  sh;
        sh = (tries < {6'd0, SHIFT_CAP}) ? tries[1:0] : SHIFT_CAP;
        stretched = {3'b000, base} << sh;
        return (stretched > {3'b000, ceiling}) ? ceiling : stretched[31:0];
    endfunction

    task automatic supervise_event(input lrs_event_t ev, output report_t rep);
        rep.action = ACT_NONE;
        unique case (ev.cmd)
            CMD_BEGIN:
                if (link_state.phase == PH_UNINIT)
                begin
                    link_state.creds_known = ev.has_creds;
                    if (!ev.has_creds)
                    begin
                        link_state.phase = PH_NOCREDS;
                        rep.action = ACT_PROVISION;
                    end
                    else
                    begin
                        link_state.overall_deadline = ev.now_ms + regs.connect_timeout_ms;
                        link_state.phase = PH_CONNECTING;
                        rep.action = ACT_CONNECT;
                    end
                end
            CMD_CONN_START:
                if (link_state.phase == PH_CONNECTING || link_state.phase == PH_RETRYWAIT)
                    link_state.phase = ev.accepted ? PH_CONNECTING : PH_FAILED;
            CMD_CONNECTED:
                if (link_state.creds_known && link_state.phase != PH_FAILED)
                begin
                    link_state.phase = PH_ONLINE;
                    link_state.retry_count = '0;
                    link_state.cred_fail_count = '0;
                    link_state.reason = '0;
                end
            CMD_DISCONN:
                if (link_state.creds_known && link_state.phase != PH_FAILED &&
                    link_state.phase != PH_PROVISION)
                begin
                    link_state.reason = ev.drop_reason;
                    // a drop from online restarts the connect budget
                    if (link_state.phase == PH_ONLINE)
                    begin
                        link_state.overall_deadline = ev.now_ms + regs.connect_timeout_ms;
                        link_state.retry_count = '0;
                        link_state.cred_fail_count = '0;
                    end
                    if (ev.cred_failure && link_state.cred_fail_count != COUNT_MAX)
                        link_state.cred_fail_count = link_state.cred_fail_count + 8'd1;
                    if (link_state.cred_fail_count >= regs.cred_fail_limit)
                        link_state.phase = PH_PROVISION;
                    else
                    begin
                        if (link_state.retry_count != COUNT_MAX)
                            link_state.retry_count = link_state.retry_count + 8'd1;
                        link_state.retry_time = ev.now_ms +
                            backoff_ms(link_state.retry_count, regs.backoff_base,
                                       regs.backoff_cap);
                        link_state.phase = PH_RETRYWAIT;
                    end
                end
            CMD_TICK:
                if (link_state.phase == PH_NOCREDS)
                begin
                    link_state.phase = PH_PROVISION;
                    rep.action = ACT_PROVISION;
                end
                else if ((link_state.phase == PH_CONNECTING ||
                          link_state.phase == PH_RETRYWAIT) &&
                         reached(ev.now_ms, link_state.overall_deadline))
                begin
                    link_state.phase = PH_PROVISION;
                    rep.action = ACT_PROVISION;
                end
                else if (link_state.phase == PH_RETRYWAIT &&
                         reached(ev.now_ms, link_state.retry_time))
                begin
                    link_state.phase = PH_CONNECTING;
                    rep.action = ACT_CONNECT;
                end
            CMD_FAIL:
                link_state.phase = PH_FAILED;
            default: ;
        endcase
        rep.phase  = link_state.phase;
        rep.reason = link_state.reason;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lrs_event_t ev;
        report_t    want;
        report_t    seen;
        if (!rst_n)
        begin
            regs.backoff_base       = RETRY_BASE_RST;
            regs.backoff_cap        = RETRY_MAX_RST;
            regs.connect_timeout_ms = TIMEOUT_RST;
            regs.cred_fail_limit    = FAIL_LIMIT_RST;
            link_state       = '0;
            link_state.phase = PH_UNINIT;
            owed_reports.delete();
            miss_tally = 0;
            beats_seen = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                unique case (cfg_index)
                    REG_RETRY_BASE: regs.backoff_base       = cfg_data;
                    REG_RETRY_MAX:  regs.backoff_cap        = cfg_data;
                    REG_TIMEOUT:    regs.connect_timeout_ms = cfg_data;
                    REG_FAIL_LIMIT: regs.cred_fail_limit    = cfg_data[7:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
            begin
                ev.cmd          = cmd;
                ev.now_ms       = now_ms;
                ev.has_creds    = has_creds;
                ev.accepted     = accepted;
                ev.drop_reason  = drop_reason;
                ev.cred_failure = cred_failure;
                supervise_event(ev, want);
                owed_reports.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                seen.action = action;
                seen.phase  = phase_now;
                seen.reason = last_reason;
                if (owed_reports.size() == 0)
                begin
                    miss_tally++;
                    if (miss_tally <= 10)
                        $display({"result beat %0d arrived with nothing owed: ",
                                  "action %0d phase %0d reason %04h"},
                                 beats_seen, seen.action, seen.phase, seen.reason);
                end
                else
                begin
                    want = owed_reports.pop_front();
                    if (seen.action != want.action || seen.phase != want.phase ||
                        seen.reason != want.reason)
                    begin
                        miss_tally++;
                        if (miss_tally <= 10)
                            $display({"result beat %0d wrong: action %0d/%0d ",
                                      "phase %0d/%0d reason %04h/%04h (expected/got)"},
                                     beats_seen, want.action, seen.action, want.phase,
                                     seen.phase, want.reason, seen.reason);
                    end
                end
                beats_seen++;
            end
            mismatches <= miss_tally;
            pending    <= owed_reports.size();
        end
    end

endmodule

@@ bench/tb_link_reconnect_supervisor_unit.sv @@
`timescale 1ns / 100ps

module tb_link_reconnect_supervisor_unit;
    import lrs_pkg::*;

    // command codes the block leaves unused; they must pass through harmlessly
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // long receiver hold-off: start once this many beats have gone in
    localparam int unsigned HOLD_AT     = 120;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_RETRY_BASE;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    lrs_event_t  beat      = '0;
    logic        out_stall = 1'b0;
    logic        hold_off  = 1'b0;

    int unsigned stall_pct     = 0;
    int unsigned send_idle_pct = 0;
    int unsigned beats_sent    = 0;
    logic [31:0] ms_clock;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [1:0]  action;
    wire logic [2:0]  phase_now;
    wire logic [15:0] last_reason;
    int unsigned      mismatches;
    int unsigned      pending;

    link_reconnect_supervisor_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (beat.cmd),
        .now_ms       (beat.now_ms),
        .has_creds    (beat.has_creds),
        .accepted     (beat.accepted),
        .drop_reason  (beat.drop_reason),
        .cred_failure (beat.cred_failure),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .phase_now    (phase_now),
        .last_reason  (last_reason)
    );

    // Predict and compare beside the block; only the counts come back here.
    lrs_result_checker report_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (beat.cmd),
        .now_ms       (beat.now_ms),
        .has_creds    (beat.has_creds),
        .accepted     (beat.accepted),
        .drop_reason  (beat.drop_reason),
        .cred_failure (beat.cred_failure),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .phase_now    (phase_now),
        .last_reason  (last_reason),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    // Receiver: stall at the phase's rate, and solidly while the hold-off runs.
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Hold the output off for a long stretch while the sender keeps offering,
    // so the result register and the input register both fill and in_stall rises.
    initial
    begin
        wait (beats_sent >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one beat: optionally idle first, then hold valid and payload
    // steady until the block takes it. Valid is left high on return so the
    // next beat can follow back to back.
    task automatic offer(input lrs_event_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        beat     <= ev;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic send(input logic [2:0] code, input logic [31:0] stamp, input logic hc,
                        input logic acc, input logic [15:0] reason, input logic cf);
        lrs_event_t ev;
        ev.cmd          = code;
        ev.now_ms       = stamp;
        ev.has_creds    = hc;
        ev.accepted     = acc;
        ev.drop_reason  = reason;
        ev.cred_failure = cf;
        offer(ev);
    endtask

    // Drop valid and wait until every owed result has come back. The first
    // edge lets the checker's count catch up with the last beat taken.
    task automatic settle;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; call only when idle.
    task automatic program_regs(input logic [31:0] base, input logic [31:0] ceiling,
                                input logic [31:0] timeout_ms, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RETRY_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_RETRY_MAX;
        cfg_data  <= ceiling;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= timeout_ms;
        @(posedge clk);
        cfg_index <= REG_FAIL_LIMIT;
        cfg_data  <= {24'd0, limit};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random event. Mostly the live traffic of a link (ticks, drops,
    // reconnects) on a clock that creeps forward so retry and deadline
    // boundaries are crossed; now and then a jump anywhere on the 32-bit
    // clock. Begins and the spare codes are noise: report them as uncounted.
    // Rejected connects and fail are held back, since both are terminal.
    task automatic random_event(output bit counted);
        lrs_event_t  ev;
        int unsigned pick;
        int unsigned jump;
        jump = $urandom_range(99);
        if (jump < 5)
            ms_clock = $urandom();
        else if (jump < 20)
            ms_clock = ms_clock + $urandom_range(40000);
        else
            ms_clock = ms_clock + $urandom_range(2500);
        ev.now_ms       = ms_clock;
        ev.has_creds    = 1'($urandom_range(1));
        ev.accepted     = 1'b1;
        ev.drop_reason  = 16'($urandom_range(16'hFFFF));
        ev.cred_failure = ($urandom_range(99) < 30);
        pick = $urandom_range(99);
        if (pick < 35)
            ev.cmd = CMD_TICK;
        else if (pick < 60)
            ev.cmd = CMD_DISCONN;
        else if (pick < 75)
            ev.cmd = CMD_CONNECTED;
        else if (pick < 88)
            ev.cmd = CMD_CONN_START;
        else if (pick < 94)
            ev.cmd = CMD_BEGIN;
        else if (pick < 97)
            ev.cmd = CMD_SPARE6;
        else
            ev.cmd = CMD_SPARE7;
        counted = !(ev.cmd == CMD_BEGIN || ev.cmd == CMD_SPARE6 || ev.cmd == CMD_SPARE7);
        offer(ev);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned done;
        bit          counted;
        done = 0;
        while (done < quota)
        begin
            random_event(counted);
            if (counted)
                done++;
        end
    endtask

    // Back-to-back drops with no reconnect between them: drives the retry
    // counter into saturation (cf low) or the credential counter up to the
    // limit (cf high).
    task automatic disconnect_storm(input int unsigned count, input logic cf);
        repeat (count)
        begin
            ms_clock = ms_clock + $urandom_range(50);
            send(CMD_DISCONN, ms_clock, 1'($urandom_range(1)), 1'b1,
                 16'($urandom_range(16'hFFFF)), cf);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] t0;
        bit          coin;
        // start just short of the 32-bit wrap so deadlines straddle zero
        ms_clock = 32'hFFFF_F000;
        t0 = ms_clock;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under the reset register values
        // (base 1000, max 8000, timeout 30000, limit 3).
        send(CMD_TICK,       32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0); // uninitialised
        send(CMD_CONNECTED,  32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1); // no creds: drop
        send(CMD_DISCONN,    t0,            1'b1, 1'b1, 16'hFFFF, 1'b1); // no creds: drop
        send(CMD_CONN_START, t0,            1'b1, 1'b1, 16'h0000, 1'b0); // wrong phase
        send(CMD_SPARE6,     32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1);
        send(CMD_SPARE7,     32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0);
        send(CMD_BEGIN,      t0,            1'b1, 1'b0, 16'h0000, 1'b0); // -> connecting
        send(CMD_BEGIN,      t0 + 32'd1,    1'b0, 1'b1, 16'h1234, 1'b1); // second begin
        send(CMD_CONN_START, t0 + 32'd50,   1'b0, 1'b1, 16'h0000, 1'b0);
        send(CMD_TICK,       t0 + 32'd100,  1'b0, 1'b0, 16'h0000, 1'b0); // nothing due
        send(CMD_CONNECTED,  t0 + 32'd150,  1'b0, 1'b0, 16'h0000, 1'b0); // online
        // drop from online: budget restarts, first retry waits base << 1
        send(CMD_DISCONN,    t0 + 32'd200,  1'b0, 1'b0, 16'h0000, 1'b0);
        send(CMD_TICK,       t0 + 32'd1000, 1'b0, 1'b0, 16'h0000, 1'b0); // too early
        send(CMD_TICK,       t0 + 32'd2200, 1'b0, 1'b0, 16'h0000, 1'b0); // retry due
        // three credential failures reach the limit; backoff hits the shift cap
        send(CMD_DISCONN,    t0 + 32'd2300, 1'b0, 1'b0, 16'hA5A5, 1'b1);
        send(CMD_DISCONN,    t0 + 32'd2400, 1'b0, 1'b0, 16'h5A5A, 1'b1);
        send(CMD_DISCONN,    t0 + 32'd2500, 1'b0, 1'b0, 16'hFFFF, 1'b1); // provisioning
        send(CMD_DISCONN,    t0 + 32'd2600, 1'b0, 1'b0, 16'h0001, 1'b0); // reason kept
        send(CMD_TICK,       t0 + 32'd50000, 1'b0, 1'b0, 16'h0000, 1'b0);
        send(CMD_CONNECTED,  t0 + 32'd50100, 1'b0, 1'b0, 16'h0000, 1'b0); // from provisioning
        send(CMD_DISCONN,    t0 + 32'd50200, 1'b0, 1'b0, 16'h8000, 1'b0);
        send(CMD_CONN_START, t0 + 32'd50300, 1'b0, 1'b1, 16'h0000, 1'b0); // retrywait -> connecting
        send(CMD_TICK,       t0 + 32'd80200, 1'b0, 1'b0, 16'h0000, 1'b0); // exactly on deadline
        send(CMD_CONNECTED,  t0 + 32'd80300, 1'b0, 1'b0, 16'h0000, 1'b0);
        ms_clock = t0 + 32'd80300;
        settle();

        // Phase: no idling on either side; the long hold-off lands here.
        program_regs(32'd250, 32'd5000, 32'd30000, 8'd3);
        run_random(250);
        settle();

        // Phase: sender idle most cycles; top-end registers, so the shifted
        // delay overflows 32 bits and clamps, and the limit is the widest.
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
        send_idle_pct = 73;
        ms_clock = ms_clock + 32'd10;
        send(CMD_CONNECTED, ms_clock, 1'b1, 1'b1, 16'h0000, 1'b0);
        disconnect_storm(260, 1'b0);
        disconnect_storm(258, 1'b1);
        run_random(20);
        settle();

        // Phase: receiver stalls most cycles; all registers zero, so every
        // accepted drop goes straight to provisioning.
        program_regs(32'd0, 32'd0, 32'd0, 8'd0);
        send_idle_pct = 0;
        stall_pct    <= 73;
        run_random(180);
        settle();

        // Phase: both sides idle now and then, with moderate random settings.
        program_regs($urandom_range(4000, 1), $urandom_range(20000),
                     $urandom_range(60000, 5000), 8'($urandom_range(4, 1)));
        send_idle_pct = 30;
        stall_pct    <= 30;
        run_random(170);

        // Close on the terminal cases: reconnect, drop into retry wait, then
        // either a rejected connect or a fail takes the link down for good.
        coin = 1'($urandom_range(1));
        send(CMD_CONNECTED, ms_clock,          1'b1, 1'b1, 16'h0000, 1'b0);
        send(CMD_DISCONN,   ms_clock + 32'd10, 1'b0, 1'b1, 16'h7E57, 1'b0);
        if (coin)
            send(CMD_CONN_START, ms_clock + 32'd20, 1'b1, 1'b0, 16'h0000, 1'b0);
        send(CMD_FAIL,       ms_clock + 32'd30, 1'b1, 1'b1, 16'hFFFF, 1'b1);
        send(CMD_CONNECTED,  ms_clock + 32'd40, 1'b1, 1'b1, 16'h0000, 1'b0);
        send(CMD_DISCONN,    ms_clock + 32'd50, 1'b0, 1'b1, 16'h1111, 1'b1);
        send(CMD_TICK,       ms_clock + 32'd90000, 1'b0, 1'b1, 16'h0000, 1'b0);
        send(CMD_CONN_START, ms_clock + 32'd90010, 1'b0, 1'b1, 16'h0000, 1'b0);
        settle();

        // let any stray beat surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
